/* rtl/alp_pkg.sv */
// ----------------------------------------------------------------------------
// alp_pkg - shared types and constants for the acceleration limit predictor
// Cubic coefficients (Q.24), region codes, register map and the elaboration
// helpers that work out the blend end points.
// ----------------------------------------------------------------------------
package alp_pkg;

    // default fraction bits of the Q-format ports
    localparam int FRAC_BITS_DEF = 8;
    // fraction bits of the polynomial coefficients
    localparam int COEF_BITS     = 24;

    // coefficient widths (signed), one per Horner term
    localparam int C3W = 18;
    localparam int C2W = 21;
    localparam int C1W = 23;
    localparam int C0W = 26;

    // forward cubic, speed above +0.5
    localparam logic signed [C3W-1:0] FWD_C3 = 18'sd40047;
    localparam logic signed [C2W-1:0] FWD_C2 = -21'sd252989;
    localparam logic signed [C1W-1:0] FWD_C1 = -23'sd190728;
    localparam logic signed [C0W-1:0] FWD_C0 = 26'sd32167420;

    // reverse cubic, taken at minus the speed below -0.5
    localparam logic signed [C3W-1:0] REV_C3 = -18'sd81974;
    localparam logic signed [C2W-1:0] REV_C2 = 21'sd843942;
    localparam logic signed [C1W-1:0] REV_C1 = -23'sd2704752;
    localparam logic signed [C0W-1:0] REV_C0 = -26'sd23933252;

    // speed region of a word
    typedef enum logic [1:0] {
        RGN_FWD,
        RGN_BLEND,
        RGN_REV
    } region_t;

    // register map
    localparam int           ADDR_W       = 3;
    localparam int           DATA_W       = 32;
    localparam logic [ADDR_W-3:0] REG_MARGIN = 1'b0;
    localparam logic [7:0]   MARGIN_RESET = 8'd3;

    // round to nearest, ties toward +inf (elaboration only)
    function automatic longint rnd_shr(input longint x, input int s);
        longint r;
        r = (x + (longint'(1) << (s - 1))) >>> s;
        return r;
    endfunction

    // Horner cubic, coefficients Q.24, v in Q.f (elaboration only)
    function automatic longint cubic_at(input longint c3, input longint c2,
                                        input longint c1, input longint c0,
                                        input longint v,  input int f);
        longint acc;
        acc = c3;
        acc = rnd_shr(acc * v, f) + c2;
        acc = rnd_shr(acc * v, f) + c1;
        acc = rnd_shr(acc * v, f) + c0;
        return acc;
    endfunction

endpackage

/* rtl/accel_limit_predictor_core.sv */
// ----------------------------------------------------------------------------
// accel_limit_predictor_core - predicted acceleration limited by speed
// Pipeline: a word runs through the register stages below from input accept to output valid.
// Throughput: one word per cycle while out_stall is low; the next word enters while earlier ones are
//   in flight, and empty stages close up while the output side stalls.
// Reset: rst_n clears all stage valid bits; accel_margin returns to 3.
// ----------------------------------------------------------------------------
//
// Datapath, one register stage each:
//   1  region decode (fwd / blend / rev), operand u = +speed or -speed
//   2  c3*u, rate*time_step, vb*vb
//   3  round + c2, prediction sum, vb^3
//   4  acc1*u, smoothstep weight si
//   5  round + c1, (pos-neg)*si
//   6  acc2*u, blend = neg + round(product)
//   7  round + c0
//   8  region select / negate reverse cubic -> Q.24 maximum
//   9  round Q.24 -> Q.FRAC_BITS
//   10 subtract margin, compare, saturate -> output register
// The forward and reverse cubics share one Horner chain; the coefficient
// set follows the region code that travels with the word.
module accel_limit_predictor_core #(
    parameter int FRAC_BITS = alp_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alp_pkg::ADDR_W-1:0]        paddr,
    input  logic [alp_pkg::DATA_W-1:0]        pwdata,
    output logic [alp_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                accel_now,
    input  logic signed [15:0]                accel_rate,
    input  logic signed [15:0]                speed,
    input  logic        [15:0]                time_step,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                accel_init,
    output logic signed [15:0]                accel_max,
    output logic                              was_limited
);

    import alp_pkg::*;

    // ------------------------------------------------------------------
    // widths, most following from FRAC_BITS
    // ------------------------------------------------------------------
    localparam int NSTG   = 10;
    localparam int UW     = 17;                 // +/- speed, -(-32768) fits
    localparam int VBW    = FRAC_BITS + 1;      // speed inside the blend band
    localparam int V2W    = 2 * VBW;
    localparam int V3W    = 3 * VBW;
    localparam int RTW    = 33;                 // rate * time_step
    localparam int P1W    = C3W + UW;
    localparam int A1W    = 34 - FRAC_BITS;
    localparam int P2W    = A1W + UW;
    localparam int A2W    = 50 - 2 * FRAC_BITS;
    localparam int P3W    = A2W + UW;
    localparam int A3W    = 66 - 3 * FRAC_BITS;
    localparam int QW     = A3W + 1;            // Q.24 maximum
    localparam int MW     = 44 - 2 * FRAC_BITS; // maximum in Q.FRAC_BITS
    localparam int LW     = MW + 1;             // maximum less margin
    localparam int PW     = 34 - FRAC_BITS;     // prediction
    localparam int KW     = (LW > PW) ? LW : PW;
    localparam int SIW    = 27;                 // smoothstep weight, Q.24
    localparam int DW     = 28;                 // pos - neg
    localparam int BPW    = DW + SIW;

    localparam int HALF_F   = 1 << (FRAC_BITS - 1);
    localparam int SI_BASE  = 1 << (COEF_BITS - 1);
    localparam int RND_COEF = 1 << (COEF_BITS - 1);
    localparam int RND_MAX  = 1 << (COEF_BITS - FRAC_BITS - 1);

    // 2*v^3 is Q.(3F); bring it to Q.24 by left or rounded right shift
    localparam bit CUBE_UP  = (3 * FRAC_BITS <= COEF_BITS);
    localparam int CUBE_SHL = CUBE_UP ? (COEF_BITS - 3 * FRAC_BITS) : 0;
    localparam int CUBE_SHR = CUBE_UP ? 0 : (3 * FRAC_BITS - COEF_BITS);
    localparam int CUBE_RND = CUBE_UP ? 0 : (1 << (CUBE_SHR - 1));

    localparam logic signed [UW-1:0] HALF_V  = UW'(HALF_F);
    localparam logic signed [UW-1:0] NHALF_V = -UW'(HALF_F);

    // blend end points, worked out at elaboration
    localparam longint POS_HALF = cubic_at(FWD_C3, FWD_C2, FWD_C1, FWD_C0,
                                           longint'(HALF_F), FRAC_BITS);
    localparam longint NEG_HALF = -cubic_at(REV_C3, REV_C2, REV_C1, REV_C0,
                                            longint'(HALF_F), FRAC_BITS);
    localparam logic signed [DW-1:0] DIFF_Q = DW'(POS_HALF - NEG_HALF);
    localparam logic signed [QW-1:0] NEG_Q  = QW'(NEG_HALF);

    localparam logic signed [KW-1:0] SAT_HI_K = KW'(32767);
    localparam logic signed [KW-1:0] SAT_LO_K = -KW'(32768);
    localparam logic signed [MW-1:0] SAT_HI_M = MW'(32767);
    localparam logic signed [MW-1:0] SAT_LO_M = -MW'(32768);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [7:0] accel_margin_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_MARGIN))
        begin
            accel_margin_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_MARGIN: prdata = DATA_W'(accel_margin_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage control: a stage advances when empty or when the next one does
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] adv;
    logic            in_acc;
    logic            out_acc;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign vld_next = (adv & vld_in) | (~adv & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    // ------------------------------------------------------------------
    // stage 1: region decode
    // ------------------------------------------------------------------
    logic signed [UW-1:0]  speed_x;
    region_t               rgn_next;
    logic signed [UW-1:0]  u_next;
    logic signed [VBW-1:0] vb_next;

    region_t               s1_rgn_reg;
    logic signed [15:0]    s1_ab_reg;
    logic signed [15:0]    s1_rate_reg;
    logic        [15:0]    s1_t_reg;
    logic signed [UW-1:0]  s1_u_reg;
    logic signed [VBW-1:0] s1_vb_reg;

    always_comb
    begin
        speed_x = UW'(speed);
        // region edges (+/-0.5 exactly) belong to the blend band
        if (speed_x > HALF_V)
        begin
            rgn_next = RGN_FWD;
        end
        else if (speed_x >= NHALF_V)
        begin
            rgn_next = RGN_BLEND;
        end
        else
        begin
            rgn_next = RGN_REV;
        end
        u_next  = (rgn_next == RGN_REV) ? -speed_x : speed_x;
        vb_next = VBW'(speed);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_rgn_reg  <= rgn_next;
            s1_ab_reg   <= accel_now;
            s1_rate_reg <= accel_rate;
            s1_t_reg    <= time_step;
            s1_u_reg    <= u_next;
            s1_vb_reg   <= vb_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: first products
    // ------------------------------------------------------------------
    logic signed [C3W-1:0] c3_sel;
    logic signed [P1W-1:0] p1_next;
    logic signed [RTW-1:0] rt_next;
    logic signed [V2W-1:0] v2_next;

    region_t               s2_rgn_reg;
    logic signed [15:0]    s2_ab_reg;
    logic signed [UW-1:0]  s2_u_reg;
    logic signed [VBW-1:0] s2_vb_reg;
    logic signed [P1W-1:0] s2_p1_reg;
    logic signed [RTW-1:0] s2_rt_reg;
    logic signed [V2W-1:0] s2_v2_reg;

    always_comb
    begin
        c3_sel  = (s1_rgn_reg == RGN_REV) ? REV_C3 : FWD_C3;
        p1_next = c3_sel * s1_u_reg;
        rt_next = s1_rate_reg * $signed({1'b0, s1_t_reg});
        v2_next = s1_vb_reg * s1_vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_rgn_reg <= s1_rgn_reg;
            s2_ab_reg  <= s1_ab_reg;
            s2_u_reg   <= s1_u_reg;
            s2_vb_reg  <= s1_vb_reg;
            s2_p1_reg  <= p1_next;
            s2_rt_reg  <= rt_next;
            s2_v2_reg  <= v2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: first Horner sum, prediction, v^3
    // ------------------------------------------------------------------
    logic signed [C2W-1:0] c2_sel;
    logic signed [P1W:0]   p1_rnd;
    logic signed [P1W:0]   p1_sh;
    logic signed [A1W-1:0] acc1_next;
    logic signed [RTW:0]   rt_rnd;
    logic signed [RTW:0]   rt_sh;
    logic signed [PW-1:0]  pred_next;
    logic signed [V3W-1:0] v3_next;

    region_t               s3_rgn_reg;
    logic signed [UW-1:0]  s3_u_reg;
    logic signed [VBW-1:0] s3_vb_reg;
    logic signed [A1W-1:0] s3_acc1_reg;
    logic signed [PW-1:0]  s3_pred_reg;
    logic signed [V3W-1:0] s3_v3_reg;

    always_comb
    begin
        c2_sel    = (s2_rgn_reg == RGN_REV) ? REV_C2 : FWD_C2;
        p1_rnd    = (P1W+1)'(s2_p1_reg) + (P1W+1)'(HALF_F);
        p1_sh     = p1_rnd >>> FRAC_BITS;
        acc1_next = A1W'(p1_sh) + A1W'(c2_sel);
        // prediction: accel_now + round(rate * time_step)
        rt_rnd    = (RTW+1)'(s2_rt_reg) + (RTW+1)'(HALF_F);
        rt_sh     = rt_rnd >>> FRAC_BITS;
        pred_next = PW'(s2_ab_reg) + PW'(rt_sh);
        v3_next   = s2_v2_reg * s2_vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_rgn_reg  <= s2_rgn_reg;
            s3_u_reg    <= s2_u_reg;
            s3_vb_reg   <= s2_vb_reg;
            s3_acc1_reg <= acc1_next;
            s3_pred_reg <= pred_next;
            s3_v3_reg   <= v3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: second product, smoothstep weight
    //   si = 0.5 + 1.5 v - 2 v^3, in Q.24
    // ------------------------------------------------------------------
    logic signed [P2W-1:0] p2_next;
    logic signed [SIW-1:0] si_lin;
    logic signed [V3W:0]   v3x2;
    logic signed [V3W:0]   v3_rnd;
    logic signed [SIW-1:0] cube_term;
    logic signed [SIW-1:0] si_next;

    region_t               s4_rgn_reg;
    logic signed [UW-1:0]  s4_u_reg;
    logic signed [PW-1:0]  s4_pred_reg;
    logic signed [P2W-1:0] s4_p2_reg;
    logic signed [SIW-1:0] s4_si_reg;

    always_comb
    begin
        p2_next = s3_acc1_reg * s3_u_reg;
        // 1.5v in Q.24 as v<<(23-F) + v<<(24-F)
        si_lin  = (SIW'(s3_vb_reg) <<< (COEF_BITS - 1 - FRAC_BITS))
                + (SIW'(s3_vb_reg) <<< (COEF_BITS - FRAC_BITS));
        v3x2    = (V3W+1)'(s3_v3_reg) <<< 1;
        v3_rnd  = (v3x2 + (V3W+1)'(CUBE_RND)) >>> CUBE_SHR;
        if (CUBE_UP)
        begin
            cube_term = SIW'(v3x2) <<< CUBE_SHL;
        end
        else
        begin
            cube_term = SIW'(v3_rnd);
        end
        si_next = SIW'(SI_BASE) + si_lin - cube_term;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_rgn_reg  <= s3_rgn_reg;
            s4_u_reg    <= s3_u_reg;
            s4_pred_reg <= s3_pred_reg;
            s4_p2_reg   <= p2_next;
            s4_si_reg   <= si_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: second Horner sum, blend product
    // ------------------------------------------------------------------
    logic signed [C1W-1:0] c1_sel;
    logic signed [P2W:0]   p2_rnd;
    logic signed [P2W:0]   p2_sh;
    logic signed [A2W-1:0] acc2_next;
    logic signed [BPW-1:0] bp_next;

    region_t               s5_rgn_reg;
    logic signed [UW-1:0]  s5_u_reg;
    logic signed [PW-1:0]  s5_pred_reg;
    logic signed [A2W-1:0] s5_acc2_reg;
    logic signed [BPW-1:0] s5_bp_reg;

    always_comb
    begin
        c1_sel    = (s4_rgn_reg == RGN_REV) ? REV_C1 : FWD_C1;
        p2_rnd    = (P2W+1)'(s4_p2_reg) + (P2W+1)'(HALF_F);
        p2_sh     = p2_rnd >>> FRAC_BITS;
        acc2_next = A2W'(p2_sh) + A2W'(c1_sel);
        bp_next   = DIFF_Q * s4_si_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_rgn_reg  <= s4_rgn_reg;
            s5_u_reg    <= s4_u_reg;
            s5_pred_reg <= s4_pred_reg;
            s5_acc2_reg <= acc2_next;
            s5_bp_reg   <= bp_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: third product, blend sum
    // ------------------------------------------------------------------
    logic signed [P3W-1:0] p3_next;
    logic signed [BPW:0]   bp_rnd;
    logic signed [BPW:0]   bp_sh;
    logic signed [QW-1:0]  bl_next;

    region_t               s6_rgn_reg;
    logic signed [PW-1:0]  s6_pred_reg;
    logic signed [P3W-1:0] s6_p3_reg;
    logic signed [QW-1:0]  s6_bl_reg;

    always_comb
    begin
        p3_next = s5_acc2_reg * s5_u_reg;
        bp_rnd  = (BPW+1)'(s5_bp_reg) + (BPW+1)'(RND_COEF);
        bp_sh   = bp_rnd >>> COEF_BITS;
        bl_next = NEG_Q + QW'(bp_sh);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_rgn_reg  <= s5_rgn_reg;
            s6_pred_reg <= s5_pred_reg;
            s6_p3_reg   <= p3_next;
            s6_bl_reg   <= bl_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: last Horner sum
    // ------------------------------------------------------------------
    logic signed [C0W-1:0] c0_sel;
    logic signed [P3W:0]   p3_rnd;
    logic signed [P3W:0]   p3_sh;
    logic signed [A3W-1:0] acc3_next;

    region_t               s7_rgn_reg;
    logic signed [PW-1:0]  s7_pred_reg;
    logic signed [A3W-1:0] s7_acc3_reg;
    logic signed [QW-1:0]  s7_bl_reg;

    always_comb
    begin
        c0_sel    = (s6_rgn_reg == RGN_REV) ? REV_C0 : FWD_C0;
        p3_rnd    = (P3W+1)'(s6_p3_reg) + (P3W+1)'(HALF_F);
        p3_sh     = p3_rnd >>> FRAC_BITS;
        acc3_next = A3W'(p3_sh) + A3W'(c0_sel);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_rgn_reg  <= s6_rgn_reg;
            s7_pred_reg <= s6_pred_reg;
            s7_acc3_reg <= acc3_next;
            s7_bl_reg   <= s6_bl_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: pick the region's maximum (reverse cubic is negated)
    // ------------------------------------------------------------------
    logic signed [QW-1:0] q24_next;

    logic signed [PW-1:0] s8_pred_reg;
    logic signed [QW-1:0] s8_q24_reg;

    always_comb
    begin
        case (s7_rgn_reg)
            RGN_FWD:   q24_next = QW'(s7_acc3_reg);
            RGN_REV:   q24_next = -QW'(s7_acc3_reg);
            RGN_BLEND: q24_next = s7_bl_reg;
            default:   q24_next = QW'(s7_acc3_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s8_pred_reg <= s7_pred_reg;
            s8_q24_reg  <= q24_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: Q.24 -> Q.FRAC_BITS
    // ------------------------------------------------------------------
    logic signed [QW:0]   q_rnd;
    logic signed [QW:0]   q_sh;
    logic signed [MW-1:0] maxf_next;

    logic signed [PW-1:0] s9_pred_reg;
    logic signed [MW-1:0] s9_maxf_reg;

    always_comb
    begin
        q_rnd     = (QW+1)'(s8_q24_reg) + (QW+1)'(RND_MAX);
        q_sh      = q_rnd >>> (COEF_BITS - FRAC_BITS);
        maxf_next = MW'(q_sh);
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s9_pred_reg <= s8_pred_reg;
            s9_maxf_reg <= maxf_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: margin, compare, saturate into the output register
    //   on a tie the prediction wins and was_limited stays low
    // ------------------------------------------------------------------
    logic signed [LW-1:0] limit;
    logic signed [KW-1:0] limit_k;
    logic signed [KW-1:0] pred_k;
    logic signed [KW-1:0] res_k;
    logic                 lim_next;
    logic signed [15:0]   init_next;
    logic signed [15:0]   max_next;

    logic signed [15:0]   s10_init_reg;
    logic signed [15:0]   s10_max_reg;
    logic                 s10_lim_reg;

    always_comb
    begin
        limit    = LW'(s9_maxf_reg) - LW'($signed({1'b0, accel_margin_reg}));
        limit_k  = KW'(limit);
        pred_k   = KW'(s9_pred_reg);
        lim_next = limit_k < pred_k;
        res_k    = lim_next ? limit_k : pred_k;

        if (res_k > SAT_HI_K)
        begin
            init_next = 16'sh7fff;
        end
        else if (res_k < SAT_LO_K)
        begin
            init_next = -16'sh8000;
        end
        else
        begin
            init_next = 16'(res_k);
        end

        if (s9_maxf_reg > SAT_HI_M)
        begin
            max_next = 16'sh7fff;
        end
        else if (s9_maxf_reg < SAT_LO_M)
        begin
            max_next = -16'sh8000;
        end
        else
        begin
            max_next = 16'(s9_maxf_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            s10_init_reg <= init_next;
            s10_max_reg  <= max_next;
            s10_lim_reg  <= lim_next;
        end
    end

    assign accel_init  = s10_init_reg;
    assign accel_max   = s10_max_reg;
    assign was_limited = s10_lim_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the limited result never lies above the saturated maximum accel_max
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accel_init <= accel_max))
    else $error("accel_init above accel_max");

    // input is held off only while the first stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
    else $error("input stalled with stage 1 empty");

    // words in flight change only by accepts on either side
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(vld_reg) == $past($countones(vld_reg))
                          + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("word lost or duplicated in pipeline");

endmodule
